// File: design/sdq_pkg.sv
// Shared types and constants for the sorted deque store.
package sdq_pkg;

    // Storage geometry
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 6;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Read select trees: cells are grouped, one registered partial per group
    localparam int GROUP = 8;
    localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SORTED     = 3'd4,
        ACT_SWAP       = 3'd5,
        ACT_READ       = 3'd6
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_INS,
        ST_SHL,
        ST_RD1,
        ST_RD2
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS_NEW,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_LOAD_A,
        CELL_LOAD_B
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     cmp_en;
    } t_cell_ctl;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] value_out;
    } t_res;

endpackage

// File: design/sorted_deque_store.sv
// Top level of the sorted deque store: command FSM, cell chain and read trees.
//
// Usage: present a request on i_req and raise start; it is taken at a rising
// edge where start is high and busy is low. Each request gives exactly one
// result on o_res, valid for the single cycle in which o_done is high. The
// receiver cannot stall, so the result must be captured in that cycle.
// Path from the accepting edge to the o_done cycle:
//   refused request (full, empty, out of range) or unused code: done from idle
//   push front, push back, pop front: one insert or shift state
//   sorted insert: the per-cell compare state, then the insert state
//   pop back, read, swap: states RD1 and RD2 (group partials registered)
// busy stays high until the result is produced and does not rise for a refused
// request; the next request can be taken in the o_done cycle.
// The per-cell compare stage and the register stage of the read trees
// set these paths. Reset (i_rst_n low, synchronous) empties the store and
// returns to idle; entry contents are not cleared, only the count.
module sorted_deque_store import sdq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [ACT_W-1:0]        r_act, n_act;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [IDX_W-1:0]        r_idx_a, n_idx_a;
    logic [IDX_W-1:0]        r_idx_b, n_idx_b;
    logic                    r_done, n_done;
    t_res                    r_res, n_res;

    logic [DEPTH-1:0][DATA_W-1:0] w_vals;
    logic [DEPTH-1:0]             w_gt;
    logic [DEPTH-1:0]             w_mask;
    logic [DEPTH-1:0]             w_pre;
    logic [DEPTH-1:0]             w_prev;
    t_cell_ctl [DEPTH-1:0]        w_ctl;
    logic [DATA_W-1:0]            w_rd_a, w_rd_b;
    logic [CMP_W-1:0]             w_pos_ext, w_cnt_ext;

    assign w_pos_ext = CMP_W'(i_req.position);
    assign w_cnt_ext = CMP_W'(r_count);

    // Advance the command FSM and build the result
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_act   = r_act;
        n_val   = r_val;
        n_idx_a = r_idx_a;
        n_idx_b = r_idx_b;
        n_done  = 1'b0;
        n_res   = r_res;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_act   = i_req.action;
                    n_val   = i_req.value;
                    n_res.status    = STAT_OK;
                    n_res.count     = r_count;
                    n_res.value_out = '0;
                    case (i_req.action) inside
                        ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_SORTED: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_res.status = STAT_FULL;
                                n_done       = 1'b1;
                            end else if (i_req.action == ACT_SORTED) begin
                                n_state = ST_CMP;
                            end else begin
                                n_state = ST_INS;
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_BACK: begin
                            if (r_count == '0) begin
                                n_res.status = STAT_EMPTY;
                                n_done       = 1'b1;
                            end else if (i_req.action == ACT_POP_FRONT) begin
                                n_state = ST_SHL;
                            end else begin
                                n_idx_a = IDX_W'(w_cnt_ext - CMP_W'(1));
                                n_state = ST_RD1;
                            end
                        end
                        ACT_SWAP, ACT_READ: begin
                            if (r_count == '0) begin
                                n_res.status = STAT_EMPTY;
                                n_done       = 1'b1;
                            end else if (w_pos_ext >= w_cnt_ext) begin
                                n_res.status = STAT_RANGE;
                                n_done       = 1'b1;
                            end else begin
                                n_idx_a = IDX_W'(w_pos_ext);
                                n_idx_b = IDX_W'(w_cnt_ext - CMP_W'(1) - w_pos_ext);
                                n_state = ST_RD1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_CMP: begin
                n_state = ST_INS;
            end
            ST_INS: begin
                n_count         = r_count + CNT_W'(1);
                n_res.status    = STAT_OK;
                n_res.count     = n_count;
                n_res.value_out = '0;
                n_done          = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SHL: begin
                n_count         = r_count - CNT_W'(1);
                n_res.status    = STAT_OK;
                n_res.count     = n_count;
                n_res.value_out = w_vals[0];
                n_done          = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_RD1: begin
                n_state = ST_RD2;
            end
            ST_RD2: begin
                n_res.status    = STAT_OK;
                n_res.value_out = '0;
                if (r_act == ACT_POP_BACK) begin
                    n_count         = r_count - CNT_W'(1);
                    n_res.value_out = w_rd_a;
                end else if (r_act == ACT_READ) begin
                    n_res.value_out = w_rd_a;
                end
                n_res.count = n_count;
                n_done      = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Hold the request and result payload
    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_val   <= n_val;
        r_idx_a <= n_idx_a;
        r_idx_b <= n_idx_b;
        r_res   <= n_res;
    end

    // Mark cells at or past the insert point: front all, back free tail, sorted also greater
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            case (r_act)
                ACT_PUSH_FRONT: w_mask[i] = 1'b1;
                ACT_PUSH_BACK:  w_mask[i] = (CNT_W'(i) >= r_count);
                default:        w_mask[i] = (CNT_W'(i) >= r_count) | w_gt[i];
            endcase
        end
    end

    // Prefix OR over the chain in log steps
    always_comb begin
        logic [DEPTH-1:0] pf;
        logic [DEPTH-1:0] nx;
        pf = w_mask;
        for (int l = 0; l < IDX_W; l++) begin
            nx = pf;
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    nx[i] = pf[i] | pf[i - (1 << l)];
                end
            end
            pf = nx;
        end
        w_pre = pf;
    end

    assign w_prev = {w_pre[DEPTH-2:0], 1'b0};

    // Drive each cell's operation for the current step
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].op     = CELL_HOLD;
            w_ctl[i].cmp_en = (r_state == ST_CMP);
            case (r_state)
                ST_INS: begin
                    if (w_pre[i]) begin
                        w_ctl[i].op = w_prev[i] ? CELL_TAKE_LEFT : CELL_INS_NEW;
                    end
                end
                ST_SHL: begin
                    w_ctl[i].op = CELL_TAKE_RIGHT;
                end
                ST_RD2: begin
                    if (r_act == ACT_SWAP) begin
                        if (IDX_W'(i) == r_idx_a) begin
                            w_ctl[i].op = CELL_LOAD_B;
                        end else if (IDX_W'(i) == r_idx_b) begin
                            w_ctl[i].op = CELL_LOAD_A;
                        end
                    end
                end
                default: begin
                    w_ctl[i].op = CELL_HOLD;
                end
            endcase
        end
    end

    // Chain of cells, front at index zero
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = r_val;
        end else begin : g_mid_l
            assign w_left = w_vals[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_vals[i+1];
        end
        sdq_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl[i]),
            .i_left   (w_left),
            .i_right  (w_right),
            .i_new    (r_val),
            .i_load_a (w_rd_a),
            .i_load_b (w_rd_b),
            .o_val    (w_vals[i]),
            .o_gt     (w_gt[i])
        );
    end

    sdq_sel_tree u_tree_a (
        .i_clk  (i_clk),
        .i_vals (w_vals),
        .i_idx  (r_idx_a),
        .o_val  (w_rd_a)
    );

    sdq_sel_tree u_tree_b (
        .i_clk  (i_clk),
        .i_vals (w_vals),
        .i_idx  (r_idx_b),
        .o_val  (w_rd_b)
    );

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == STAT_FULL) |-> (o_res.count == CNT_W'(DEPTH)))
        else $error("full status without a full store");

    a_rd_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD1) |=> (r_state == ST_RD2))
        else $error("read tree stage skipped");

    a_rd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD2) |=> o_done)
        else $error("read result missing");
`endif

endmodule

// File: design/sdq_cell.sv
// One storage cell of the deque chain: value register plus compare flag.
module sdq_cell import sdq_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    input  logic signed [DATA_W-1:0] i_new,
    input  logic signed [DATA_W-1:0] i_load_a,
    input  logic signed [DATA_W-1:0] i_load_b,
    output logic signed [DATA_W-1:0] o_val,
    output logic                     o_gt
);

    logic signed [DATA_W-1:0] r_val, n_val;
    logic                     r_gt, n_gt;

    // Select the next value from the neighbors or the broadcast buses
    always_comb begin
        case (i_ctl.op)
            CELL_INS_NEW:    n_val = i_new;
            CELL_TAKE_LEFT:  n_val = i_left;
            CELL_TAKE_RIGHT: n_val = i_right;
            CELL_LOAD_A:     n_val = i_load_a;
            CELL_LOAD_B:     n_val = i_load_b;
            default:         n_val = r_val;
        endcase
    end

    // Capture whether the held entry is greater than the incoming key
    assign n_gt = i_ctl.cmp_en ? (r_val > i_new) : r_gt;

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_gt  <= n_gt;
    end

    assign o_val = r_val;
    assign o_gt  = r_gt;

endmodule

// File: design/sdq_sel_tree.sv
// Two-stage select tree (group partials registered, then merged) that reads one cell by index.
module sdq_sel_tree import sdq_pkg::*; (
    input  logic                          i_clk,
    input  logic [DEPTH-1:0][DATA_W-1:0]  i_vals,
    input  logic [IDX_W-1:0]              i_idx,
    output logic [DATA_W-1:0]             o_val
);

    logic [NGRP-1:0][DATA_W-1:0] r_part, n_part;

    // Reduce each group of cells to one partial
    always_comb begin
        n_part = '0;
        for (int g = 0; g < NGRP; g++) begin
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < DEPTH) begin
                    if (i_idx == IDX_W'(g * GROUP + j)) begin
                        n_part[g] = n_part[g] | i_vals[g * GROUP + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
    end

    // Merge the group partials
    always_comb begin
        o_val = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_val = o_val | r_part[g];
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted deque store: queued requests, shadow store, result check.
module testbench;
    import sdq_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int MAX_GAP       = 16;
    localparam int QUIET_LIMIT   = 500;
    localparam int SETTLE_CYCLES = 10;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // Stimulus phases steer the fill level of the store
    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_SORTED,
        PH_MIX
    } t_phase;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    t_req request_q[$];
    t_res pending_results[$];

    // Shadow copy of the store contents, front at index 0
    logic signed [DATA_W-1:0] shadow_vals [DEPTH];
    int shadow_cnt = 0;

    int plan_cnt    = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int quiet_cycles = 0;
    int fail_cnt    = 0;

    sorted_deque_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always #10 i_clk = ~i_clk;

    // Apply one request to the shadow store and return the result it should give
    function automatic t_res shadow_action(t_req rq);
        t_res r;
        logic signed [DATA_W-1:0] nv;
        logic signed [DATA_W-1:0] tmp;
        int idx;
        int far;
        int k;
        r = '0;
        r.status = STAT_OK;
        nv = rq.value;
        idx = int'(rq.position);
        case (rq.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_SORTED: begin
                if (shadow_cnt >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (rq.action == ACT_PUSH_FRONT) begin
                        idx = 0;
                    end else if (rq.action == ACT_PUSH_BACK) begin
                        idx = shadow_cnt;
                    end else begin
                        // skip the leading run of entries not greater than the new value
                        idx = 0;
                        while (idx < shadow_cnt && shadow_vals[idx] <= nv)
                            idx++;
                    end
                    for (k = shadow_cnt; k > idx; k--)
                        shadow_vals[k] = shadow_vals[k-1];
                    shadow_vals[idx] = nv;
                    shadow_cnt++;
                end
            end
            ACT_POP_FRONT: begin
                if (shadow_cnt == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.value_out = shadow_vals[0];
                    for (k = 0; k < shadow_cnt - 1; k++)
                        shadow_vals[k] = shadow_vals[k+1];
                    shadow_cnt--;
                end
            end
            ACT_POP_BACK: begin
                if (shadow_cnt == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    shadow_cnt--;
                    r.value_out = shadow_vals[shadow_cnt];
                end
            end
            ACT_SWAP, ACT_READ: begin
                if (shadow_cnt == 0) begin
                    r.status = STAT_EMPTY;
                end else if (idx >= shadow_cnt) begin
                    r.status = STAT_RANGE;
                end else if (rq.action == ACT_READ) begin
                    r.value_out = shadow_vals[idx];
                end else begin
                    far = shadow_cnt - 1 - idx;
                    tmp = shadow_vals[idx];
                    shadow_vals[idx] = shadow_vals[far];
                    shadow_vals[far] = tmp;
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(shadow_cnt);
        return r;
    endfunction

    // Idle cycles before the next request, with bursts of back-to-back requests
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 80);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Queue a request and track the fill level it leads to
    function automatic void queue_request(logic [ACT_W-1:0] act,
                                          logic signed [DATA_W-1:0] val,
                                          logic [POS_W-1:0] pos);
        t_req rq;
        rq.action   = act;
        rq.value    = val;
        rq.position = pos;
        request_q.push_back(rq);
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_SORTED: if (plan_cnt < DEPTH) plan_cnt++;
            ACT_POP_FRONT, ACT_POP_BACK: if (plan_cnt > 0) plan_cnt--;
            default: ;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] draw_value(int small_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < small_pct)
            return DATA_W'(int'($urandom_range(0, 16)) - 8);
        if (r < small_pct + 10) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly positions inside the store, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] draw_position();
        if (plan_cnt > 0 && $urandom_range(0, 4) != 0)
            return POS_W'($urandom_range(0, plan_cnt - 1));
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    function automatic logic [ACT_W-1:0] draw_action(t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                if (r < 30) return ACT_PUSH_FRONT;
                if (r < 60) return ACT_PUSH_BACK;
                if (r < 75) return ACT_SORTED;
                if (r < 82) return ACT_READ;
                if (r < 88) return ACT_SWAP;
                if (r < 94) return ACT_POP_FRONT;
                return ACT_POP_BACK;
            end
            PH_DRAIN: begin
                if (r < 35) return ACT_POP_FRONT;
                if (r < 70) return ACT_POP_BACK;
                if (r < 80) return ACT_READ;
                if (r < 88) return ACT_SWAP;
                if (r < 94) return ACT_PUSH_BACK;
                return ACT_SORTED;
            end
            PH_SORTED: begin
                if (r < 55) return ACT_SORTED;
                if (r < 70) return ACT_READ;
                if (r < 78) return ACT_POP_FRONT;
                if (r < 86) return ACT_POP_BACK;
                if (r < 94) return ACT_SWAP;
                return ACT_PUSH_FRONT;
            end
            default: return ACT_W'($urandom_range(0, (1 << ACT_W) - 1));
        endcase
    endfunction

    // Driver: present queued requests, hold each until taken, then idle a random gap or go on back to back
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_req    <= '0;
            gap_left <= 0;
        end else if (start && !busy) begin
            pending_results.push_back(shadow_action(i_req));
            begin
                int g;
                g = next_gap();
                if (g == 0 && request_q.size() > 0) begin
                    // keep start high for a back-to-back request
                    i_req <= request_q.pop_front();
                end else begin
                    start    <= 1'b0;
                    gap_left <= g;
                end
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (request_q.size() > 0) begin
                i_req <= request_q.pop_front();
                start <= 1'b1;
            end
        end
    end

    // Monitor: check every result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d count %0d value %0d",
                       o_res.status, o_res.count, o_res.value_out);
                fail_cnt++;
            end else begin
                t_res want;
                want = pending_results.pop_front();
                if (o_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_res.status);
                    fail_cnt++;
                end
                if (o_res.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_res.count);
                    fail_cnt++;
                end
                if (o_res.value_out !== want.value_out) begin
                    $error("value_out: expected %0d, got %0d", want.value_out,
                           o_res.value_out);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_phase ph;
        int phase_len;
        int n;
        logic [ACT_W-1:0] act;

        // Directed: empty-store refusals, ends of the value range, sorted inserts
        queue_request(ACT_POP_FRONT, '0, '0);
        queue_request(ACT_POP_BACK, '0, '0);
        queue_request(ACT_SWAP, '0, '0);
        queue_request(ACT_READ, '0, 6'd63);
        queue_request(ACT_SORTED, 32'sd5, '0);
        queue_request(ACT_PUSH_FRONT, VAL_MIN, '0);
        queue_request(ACT_PUSH_BACK, VAL_MAX, '0);
        queue_request(ACT_SORTED, 32'sd5, '0);
        queue_request(ACT_SORTED, VAL_MAX, '0);
        queue_request(ACT_SORTED, -32'sd1, '0);
        // break the order, then insert into the unsorted store
        queue_request(ACT_PUSH_FRONT, 32'sd100, '0);
        queue_request(ACT_SORTED, 32'sd50, '0);
        queue_request(ACT_SORTED, '0, '0);
        queue_request(ACT_READ, '0, 6'd0);
        queue_request(ACT_READ, '0, 6'd8);
        queue_request(ACT_READ, '0, 6'd9);
        // middle of an odd-sized store: both offsets name one entry
        queue_request(ACT_SWAP, '0, 6'd4);
        queue_request(ACT_SWAP, '0, 6'd0);
        queue_request(ACT_SWAP, '0, 6'd63);
        queue_request(ACT_UNUSED, '1, 6'd63);
        queue_request(ACT_PUSH_BACK, '0, 6'd63);
        queue_request(ACT_POP_FRONT, '0, '0);
        queue_request(ACT_POP_BACK, '0, '0);
        queue_request(ACT_READ, '0, 6'd1);
        queue_request(ACT_PUSH_FRONT, -32'sd1, '0);

        // Random: phases that fill to full, drain to empty and exercise ordering
        n = 0;
        while (n < RANDOM_ITEMS) begin
            ph = t_phase'($urandom_range(PH_FILL, PH_MIX));
            phase_len = $urandom_range(30, 150);
            repeat (phase_len) begin
                act = draw_action(ph);
                queue_request(act, draw_value(ph == PH_SORTED ? 60 : 25), draw_position());
                n++;
            end
        end

        // Hold reset, then release at a clock edge
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || start)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
